// ===== rtl/core/dntl_pkg.sv =====
// shared constants, types and the character fold for the domain name trie lookup unit
// no dependencies; every other file in rtl/core imports this package
`timescale 1ns / 1ps

package dntl_pkg;

   localparam int NODE_COUNT      = 1024;
   localparam int NODE_W          = $clog2(NODE_COUNT);
   localparam int ALPHABET_SIZE   = 38;
   localparam int SYM_W           = $clog2(ALPHABET_SIZE);
   localparam int SYM_LETTER_BASE = 10;
   localparam int SYM_DOT         = 36;
   localparam int SYM_DASH        = 37;
   localparam int CHAR_W          = 8;
   localparam int ADDR_W          = 32;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_MISS    = 2'd1,
      ST_BADCHAR = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_QUERY  = 1'b1
   } action_type;

   typedef logic [NODE_W-1:0] node_type;
   typedef logic [SYM_W-1:0]  sym_type;
   typedef node_type [ALPHABET_SIZE-1:0] row_type;

   typedef struct packed {
      logic    bad;
      sym_type sym;
   } fold_type;

   // controller to datapath
   typedef struct packed {
      logic clear_row;
      logic capture;
      logic commit;
      logic load_walk;
      logic load_finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic last;
      logic need_finish;
   } sts_type;

   function automatic fold_type fold_symbol(input logic [CHAR_W-1:0] c);
      fold_type f;
      f.bad = 1'b0;
      f.sym = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         f.sym = SYM_W'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h5a) begin
         f.sym = SYM_W'(c - 8'h41) + SYM_W'(SYM_LETTER_BASE);
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         f.sym = SYM_W'(c - 8'h61) + SYM_W'(SYM_LETTER_BASE);
      end else if (c == 8'h2e) begin
         f.sym = SYM_W'(SYM_DOT);
      end else if (c == 8'h2d) begin
         f.sym = SYM_W'(SYM_DASH);
      end else begin
         f.bad = 1'b1;
      end
      return f;
   endfunction

endpackage

// ===== rtl/core/dntl_ifs.sv =====
// valid/ready channel interfaces for the request and response words
// depends on dntl_pkg for field widths
`timescale 1ns / 1ps

interface dntl_req_if import dntl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              action;
   logic [CHAR_W-1:0] char_code;
   logic              last_char;
   logic [ADDR_W-1:0] ip_address;

   modport source (output valid, action, char_code, last_char, ip_address, input ready);
   modport sink   (input valid, action, char_code, last_char, ip_address, output ready);
endinterface

interface dntl_rsp_if import dntl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              found;
   logic [ADDR_W-1:0] ip_result;
   logic [1:0]        status;

   modport source (output valid, found, ip_result, status, input ready);
   modport sink   (input valid, found, ip_result, status, output ready);
endinterface

// ===== rtl/core/dntl_datapath.sv =====
// datapath: child row memory, end mark and address memories, cursor, allocator, result register
// depends on dntl_pkg; driven by dntl_ctrl through cmd_type and sts_type
`timescale 1ns / 1ps

module dntl_datapath import dntl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic              req_action,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic              req_last_char,
   input  logic [ADDR_W-1:0] req_ip_address,
   output logic              rsp_found,
   output logic [ADDR_W-1:0] rsp_ip_result,
   output logic [1:0]        rsp_status
);

   // memories
   row_type           child_mem [NODE_COUNT];
   logic              end_mem   [NODE_COUNT];
   logic [ADDR_W-1:0] ip_mem    [NODE_COUNT];

   // control state
   node_type   clear_addr_ff, clear_addr_in;
   node_type   cursor_ff, cursor_in;
   node_type   nodes_ff, nodes_in;
   status_type err_ff, err_in;

   // captured word and read data
   logic              query_ff;
   logic              last_ff;
   logic              bad_ff;
   sym_type           sym_ff;
   logic [ADDR_W-1:0] ip_ff;
   row_type           row_ff;
   logic              end_rd_ff;
   logic [ADDR_W-1:0] ip_rd_ff;

   // result register
   logic              found_ff;
   logic [ADDR_W-1:0] ipres_ff;
   status_type        status_ff;

   fold_type   fold;
   node_type   child;
   node_type   new_node;
   status_type walk_err;
   node_type   walk_node;
   logic       alloc;
   logic       row_we;
   node_type   row_wa;
   row_type    row_wd;
   logic       store_we;
   logic       end_we;
   node_type   end_wa;

   assign fold = fold_symbol(req_char_code);

   always_comb begin
      child     = row_ff[sym_ff];
      new_node  = nodes_ff + node_type'(1);
      walk_err  = err_ff;
      walk_node = cursor_ff;
      alloc     = 1'b0;
      // once a name has failed, the rest of it is not walked
      if (err_ff == ST_OK) begin
         if (bad_ff) begin
            walk_err = ST_BADCHAR;
         end else if (child != '0) begin
            walk_node = child;
         end else if (query_ff) begin
            walk_err = ST_MISS;
         end else if (nodes_ff >= node_type'(NODE_COUNT - 1)) begin
            walk_err = ST_FULL;
         end else begin
            alloc     = 1'b1;
            walk_node = new_node;
         end
      end
   end

   always_comb begin
      row_wd         = row_ff;
      row_wd[sym_ff] = new_node;
      if (cmd.clear_row) begin
         row_we = 1'b1;
         row_wa = clear_addr_ff;
         row_wd = '0;
      end else begin
         row_we = cmd.commit & alloc;
         row_wa = cursor_ff;
      end
   end

   assign store_we = cmd.commit & last_ff & ~query_ff & (walk_err == ST_OK);
   assign end_we   = cmd.clear_row | store_we;
   assign end_wa   = cmd.clear_row ? clear_addr_ff : walk_node;

   always_ff @(posedge clock) begin
      if (row_we) begin
         child_mem[row_wa] <= row_wd;
      end
      if (cmd.capture) begin
         row_ff <= child_mem[cursor_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (end_we) begin
         end_mem[end_wa] <= ~cmd.clear_row;
      end
      if (store_we) begin
         ip_mem[walk_node] <= ip_ff;
      end
      if (cmd.commit) begin
         end_rd_ff <= end_mem[walk_node];
         ip_rd_ff  <= ip_mem[walk_node];
      end
   end

   always_comb begin
      clear_addr_in = clear_addr_ff;
      cursor_in     = cursor_ff;
      nodes_in      = nodes_ff;
      err_in        = err_ff;
      if (cmd.clear_row) begin
         clear_addr_in = clear_addr_ff + node_type'(1);
      end
      if (cmd.commit) begin
         if (alloc) begin
            nodes_in = new_node;
         end
         if (last_ff) begin
            cursor_in = '0;
            err_in    = ST_OK;
         end else begin
            cursor_in = walk_node;
            err_in    = walk_err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
         cursor_ff     <= '0;
         nodes_ff      <= '0;
         err_ff        <= ST_OK;
      end else begin
         clear_addr_ff <= clear_addr_in;
         cursor_ff     <= cursor_in;
         nodes_ff      <= nodes_in;
         err_ff        <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         query_ff <= (req_action == ACT_QUERY);
         last_ff  <= req_last_char;
         bad_ff   <= fold.bad;
         sym_ff   <= fold.sym;
         ip_ff    <= req_ip_address;
      end
      if (cmd.load_walk) begin
         found_ff  <= 1'b0;
         ipres_ff  <= '0;
         status_ff <= walk_err;
      end else if (cmd.load_finish) begin
         found_ff  <= end_rd_ff;
         ipres_ff  <= end_rd_ff ? ip_rd_ff : '0;
         status_ff <= end_rd_ff ? ST_OK : ST_MISS;
      end
   end

   assign sts.clear_done  = (clear_addr_ff == node_type'(NODE_COUNT - 1));
   assign sts.last        = last_ff;
   assign sts.need_finish = query_ff & (walk_err == ST_OK);

   assign rsp_found     = found_ff;
   assign rsp_ip_result = ipres_ff;
   assign rsp_status    = status_ff;

endmodule

// ===== rtl/core/dntl_ctrl.sv =====
// controller: clearing pass, per-word sequencing and response valid
// depends on dntl_pkg; drives dntl_datapath through cmd_type
`timescale 1ns / 1ps

module dntl_ctrl import dntl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_WALK,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;
   logic      blocked;

   // the response register can take a new word this cycle
   assign rsp_free = ~rsp_valid_ff | rsp_ready;
   // a result from the walk cycle waits until the response register frees up
   assign blocked  = sts.last & ~sts.need_finish & ~rsp_free;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_row = 1'b1;
            if (sts.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_WALK;
            end
         end
         S_WALK: begin
            if (!blocked) begin
               cmd.commit    = 1'b1;
               cmd.load_walk = sts.last & ~sts.need_finish;
               state_in      = (sts.last && sts.need_finish) ? S_FINISH : S_IDLE;
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               cmd.load_finish = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_walk | cmd.load_finish | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/domain_name_trie_lookup_unit.sv =====
// Domain name trie lookup unit: stores and looks up domain names, one character per
// request word, in a trie held in a node pool of NODE_COUNT nodes.
// Request channel (req_if): action (0 insert, 1 query), char_code, last_char and
// ip_address; ip_address is used on the last character of an insert.
// Response channel (rsp_if): found, ip_result, status; one response word per name,
// given for the word that carries last_char, none for the other characters.
// Sequencing: the idle state takes a character and reads the node's child row; the walk
// state walks or grows it with a write back; a query whose last character reached its
// final node then passes a finish state, which makes the response from that node's end
// mark and stored address. Each word waits for the one before, whose cursor it needs.
// Reset: after reset the child row and end mark memories are swept one row a cycle,
// all NODE_COUNT rows, with req_if.ready low; the trie then starts empty.
// Stall: a response waits in its output register while rsp_if.ready is low; request
// words that end no name still go through, and a name's last word holds in the walk
// state (a query that reached its final node holds in the finish state) until the
// register frees up.
// Depends on dntl_pkg, dntl_ifs, dntl_ctrl and dntl_datapath.
`timescale 1ns / 1ps

module domain_name_trie_lookup_unit import dntl_pkg::*; (
   input logic         clock,
   input logic         reset,
   dntl_req_if.sink    req_if,
   dntl_rsp_if.source  rsp_if
);

   cmd_type cmd;
   sts_type sts;

   dntl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dntl_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_action     (req_if.action),
      .req_char_code  (req_if.char_code),
      .req_last_char  (req_if.last_char),
      .req_ip_address (req_if.ip_address),
      .rsp_found      (rsp_if.found),
      .rsp_ip_result  (rsp_if.ip_result),
      .rsp_status     (rsp_if.status)
   );

endmodule

// ===== test/tb_domain_name_trie_lookup_unit.sv =====
// testbench for domain_name_trie_lookup_unit: drives names one character word at a time
// and checks every response word against a shadow trie held in a small scoreboard class
// depends on dntl_pkg, dntl_ifs and the rtl top level
`timescale 1ns / 1ps

module tb_domain_name_trie_lookup_unit;
   import dntl_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int VOCAB_SIZE = 24;

   typedef bit [CHAR_W-1:0] name_type [$];

   typedef struct {
      bit              found;
      bit [ADDR_W-1:0] ip;
      status_type      status;
   } answer_type;

   // shadow copy of the trie; predicts the response word of each name
   class trie_shadow;
      bit [NODE_W-1:0] child [NODE_COUNT*ALPHABET_SIZE];
      bit              end_mark [NODE_COUNT];
      bit [ADDR_W-1:0] stored_ip [NODE_COUNT];
      int unsigned     nodes_used;
      bit [NODE_W-1:0] cursor;
      status_type      name_err;
      answer_type      due [$];
      int              errors;

      function new();
         foreach (child[i]) child[i] = '0;
         foreach (end_mark[i]) begin
            end_mark[i] = 1'b0;
            stored_ip[i] = '0;
         end
         nodes_used = 0;
         cursor = '0;
         name_err = ST_OK;
         errors = 0;
      endfunction

      // symbol index 0..37, or -1 outside the alphabet
      function int fold_char(bit [CHAR_W-1:0] c);
         if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
         if (c >= 8'h41 && c <= 8'h5a) c = c | 8'h20;
         if (c >= 8'h61 && c <= 8'h7a) return int'(c) - 'h61 + SYM_LETTER_BASE;
         if (c == 8'h2e) return SYM_DOT;
         if (c == 8'h2d) return SYM_DASH;
         return -1;
      endfunction

      function int pending();
         return due.size();
      endfunction

      function void take_word(action_type act, bit [CHAR_W-1:0] c, bit lst,
                              bit [ADDR_W-1:0] ip);
         int              sym;
         int              slot;
         bit [NODE_W-1:0] nxt;
         answer_type      a;
         if (name_err == ST_OK) begin
            sym = fold_char(c);
            if (sym < 0) begin
               name_err = ST_BADCHAR;
            end else begin
               slot = int'(cursor) * ALPHABET_SIZE + sym;
               nxt = child[slot];
               if (nxt == 0) begin
                  if (act == ACT_QUERY) begin
                     name_err = ST_MISS;
                  end else if (nodes_used >= NODE_COUNT - 1) begin
                     name_err = ST_FULL;
                  end else begin
                     nodes_used++;
                     nxt = NODE_W'(nodes_used);
                     child[slot] = nxt;
                  end
               end
               if (name_err == ST_OK) cursor = nxt;
            end
         end
         if (!lst) return;
         a.found = 1'b0;
         a.ip = '0;
         a.status = ST_OK;
         if (name_err != ST_OK) begin
            a.status = name_err;
         end else if (act == ACT_INSERT) begin
            stored_ip[cursor] = ip;
            end_mark[cursor] = 1'b1;
         end else if (end_mark[cursor]) begin
            a.found = 1'b1;
            a.ip = stored_ip[cursor];
         end else begin
            a.status = ST_MISS;
         end
         due.push_back(a);
         cursor = '0;
         name_err = ST_OK;
      endfunction

      function void check_answer(logic found, logic [ADDR_W-1:0] ip, logic [1:0] st);
         answer_type want;
         if (due.size() == 0) begin
            $display("%0t: unexpected response word found=%0b ip=%h status=%0d",
                     $time, found, ip, st);
            errors++;
            return;
         end
         want = due.pop_front();
         if (found !== want.found) begin
            $display("%0t: found expected %0b actual %0b", $time, want.found, found);
            errors++;
         end
         if (ip !== want.ip) begin
            $display("%0t: ip_result expected %h actual %h", $time, want.ip, ip);
            errors++;
         end
         if (st !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, st);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   dntl_req_if req_if ();
   dntl_rsp_if rsp_if ();

   domain_name_trie_lookup_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   trie_shadow shadow = new();
   name_type   vocab [VOCAB_SIZE];
   int         words_sent = 0;
   bit         send_steady = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic bit [CHAR_W-1:0] symbol_char();
      int r;
      r = $urandom_range(0, ALPHABET_SIZE - 1);
      if (r < 10) return CHAR_W'(8'h30 + r);
      if (r < 36) return CHAR_W'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + (r - 10));
      return (r == SYM_DOT) ? 8'h2e : 8'h2d;
   endfunction

   function automatic name_type fresh_name(int len);
      name_type q;
      for (int i = 0; i < len; i++) q.push_back(symbol_char());
      return q;
   endfunction

   function automatic name_type to_name(string s);
      name_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   task automatic send_char(action_type act, bit [CHAR_W-1:0] c, bit lst,
                            bit [ADDR_W-1:0] ip);
      int gap;
      if ($urandom_range(0, 149) == 0) send_steady = !send_steady;
      gap = send_steady ? 0 : gap_len();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.action     <= act;
      req_if.char_code  <= c;
      req_if.last_char  <= lst;
      req_if.ip_address <= ip;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      shadow.take_word(act, c, lst, ip);
      words_sent++;
   endtask

   task automatic send_name(name_type nm, action_type act, bit mix_actions, bit vary_case,
                            bit [ADDR_W-1:0] ip);
      action_type      a;
      bit [CHAR_W-1:0] c;
      for (int i = 0; i < nm.size(); i++) begin
         a = mix_actions ? action_type'($urandom_range(0, 1)) : act;
         c = nm[i];
         // flip letter case at random; the unit folds it
         if (vary_case && ((c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a)) &&
             $urandom_range(0, 1))
            c = c ^ 8'h20;
         send_char(a, c, i == nm.size() - 1, (i == nm.size() - 1) ? ip : $urandom());
      end
   endtask

   task automatic wait_all_answered();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (shadow.pending() != 0);
   endtask

   task automatic random_names(int count);
      int       stop;
      int       r;
      int       k;
      name_type nm;
      stop = words_sent + count;
      while (words_sent < stop) begin
         r = $urandom_range(0, 99);
         nm = vocab[$urandom_range(0, VOCAB_SIZE - 1)];
         if (r < 45) begin
            send_name(nm, ACT_INSERT, 1'b0, 1'b1, $urandom());
         end else if (r < 72) begin
            send_name(nm, ACT_QUERY, 1'b0, 1'b1, $urandom());
         end else if (r < 80) begin
            // prefix of a known name
            k = $urandom_range(1, nm.size());
            while (nm.size() > k) void'(nm.pop_back());
            send_name(nm, ACT_QUERY, 1'b0, 1'b1, $urandom());
         end else if (r < 88) begin
            send_name(nm, ACT_QUERY, 1'b1, 1'b1, $urandom());
         end else if (r < 94) begin
            nm[$urandom_range(0, nm.size() - 1)] = CHAR_W'($urandom_range(0, 255));
            send_name(nm, action_type'($urandom_range(0, 1)), 1'b0, 1'b1, $urandom());
         end else begin
            send_name(fresh_name($urandom_range(1, 8)), action_type'($urandom_range(0, 1)),
                      1'b0, 1'b1, $urandom());
         end
      end
   endtask

   // response side: random stalls with stretches of none
   initial begin : rsp_side
      int stall;
      bit steady;
      stall = 0;
      steady = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready)
            shadow.check_answer(rsp_if.found, rsp_if.ip_result, rsp_if.status);
         if ($urandom_range(0, 199) == 0) steady = !steady;
         if (stall > 0) stall--;
         else if (!steady) stall = gap_len();
         rsp_if.ready <= (stall == 0);
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL domain_name_trie_lookup_unit");
      $finish;
   end

   initial begin : stimulus
      reset = 1'b1;
      req_if.valid      = 1'b0;
      req_if.action     = ACT_INSERT;
      req_if.char_code  = '0;
      req_if.last_char  = 1'b0;
      req_if.ip_address = '0;
      for (int i = 0; i < VOCAB_SIZE; i++) vocab[i] = fresh_name($urandom_range(1, 12));
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: fold, extremes, misses, bad characters, mixed actions
      send_name(to_name("a"), ACT_INSERT, 1'b0, 1'b0, 32'hffff_ffff);
      send_name(to_name("A"), ACT_QUERY, 1'b0, 1'b0, '0);
      send_name(to_name("Z9.-"), ACT_INSERT, 1'b0, 1'b0, 32'h0);
      send_name(to_name("z9.-"), ACT_QUERY, 1'b0, 1'b0, $urandom());
      send_name(to_name("z9"), ACT_QUERY, 1'b0, 1'b0, $urandom());
      send_name(to_name("q"), ACT_QUERY, 1'b0, 1'b0, $urandom());
      send_name(to_name("b_c"), ACT_INSERT, 1'b0, 1'b0, $urandom());
      send_char(ACT_QUERY, 8'hff, 1'b1, $urandom());
      send_char(ACT_QUERY, 8'h61, 1'b0, $urandom());
      send_char(ACT_INSERT, 8'h30, 1'b1, 32'h5a5a_a5a5);
      send_char(ACT_INSERT, 8'h61, 1'b0, $urandom());
      send_char(ACT_QUERY, 8'h30, 1'b1, $urandom());
      send_name(to_name("a"), ACT_INSERT, 1'b0, 1'b0, 32'h1234_5678);
      send_name(to_name("a"), ACT_QUERY, 1'b0, 1'b0, $urandom());
      // miss first, then a bad character that must not override it
      send_char(ACT_QUERY, 8'h78, 1'b0, $urandom());
      send_char(ACT_QUERY, 8'h00, 1'b1, $urandom());

      random_names(150);
      wait_all_answered();
      random_names(100);

      // grow the pool until it runs out, then keep going on a full trie
      while (shadow.nodes_used < NODE_COUNT - 1)
         send_name(fresh_name($urandom_range(10, 30)), ACT_INSERT, 1'b0, 1'b1, $urandom());
      repeat (4)
         send_name(fresh_name($urandom_range(2, 6)), ACT_INSERT, 1'b0, 1'b1, $urandom());
      random_names(150);

      wait_all_answered();
      repeat (8) @(posedge clock);
      if (shadow.errors == 0 && shadow.pending() == 0) begin
         $display("PASS domain_name_trie_lookup_unit");
      end else begin
         $display("FAIL domain_name_trie_lookup_unit");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/dntl_pkg.sv
rtl/core/dntl_ifs.sv
rtl/core/dntl_datapath.sv
rtl/core/dntl_ctrl.sv
rtl/core/domain_name_trie_lookup_unit.sv
test/tb_domain_name_trie_lookup_unit.sv
